### rtl/core/tstl_pkg.sv
// Package for the task slot table: lifecycle state and operation codes,
// the query beat that travels down the slot chain, and the move rule.
// No dependencies.
package tstl_pkg;

    // Operation codes carried in the func field
    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_GET    = 2'd2;

    // Lifecycle state codes
    localparam logic [2:0] ST_CREATED    = 3'd0;
    localparam logic [2:0] ST_QUEUED     = 3'd1;
    localparam logic [2:0] ST_DISPATCHED = 3'd2;
    localparam logic [2:0] ST_DONE       = 3'd3;
    localparam logic [2:0] ST_DENIED     = 3'd4;
    localparam logic [2:0] ST_FAILED     = 3'd5;

    localparam int ID_W    = 16;
    localparam int KIND_W  = 4;
    localparam int SVC_W   = 8;
    localparam int STATE_W = 3;
    localparam int NTH_W   = 4;
    localparam int LIVE_W  = 5;

    localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
    localparam logic [ID_W-1:0] ID_LAST  = 16'hFFFF;

    // Query beat handed from cell to cell; the result fields fill in on the way
    typedef struct packed {
        logic                      valid;
        logic [1:0]                func;
        logic [KIND_W-1:0]         kind;
        logic signed [SVC_W-1:0]   service;
        logic [ID_W-1:0]           tid;
        logic [STATE_W-1:0]        new_state;
        logic [NTH_W-1:0]          nth;
        logic [ID_W-1:0]           new_id;
        logic                      done;
        logic                      ok;
        logic [ID_W-1:0]           rid;
        logic [KIND_W-1:0]         rkind;
        logic signed [SVC_W-1:0]   rsvc;
        logic [STATE_W-1:0]        rstate;
    } tstl_query_t;

    // Allowed lifecycle moves
    function automatic logic move_allowed(input logic [STATE_W-1:0] from,
                                          input logic [STATE_W-1:0] to);
        logic allowed;
        unique case (from)
            ST_CREATED:
                allowed = (to == ST_QUEUED) || (to == ST_DENIED) || (to == ST_FAILED);
            ST_QUEUED:
                allowed = (to == ST_DISPATCHED) || (to == ST_DENIED) || (to == ST_FAILED);
            ST_DISPATCHED:
                allowed = (to == ST_DONE) || (to == ST_FAILED);
            default:
                allowed = 1'b0;
        endcase
        return allowed;
    endfunction

endpackage

### rtl/core/tstl_ifs.sv
// Valid/ready channel interfaces for the task slot table request and response.
// Depends on tstl_pkg for field widths.
interface tstl_req_if
    import tstl_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic [KIND_W-1:0]       task_kind;
    logic signed [SVC_W-1:0] service_index;
    logic [ID_W-1:0]         task_id;
    logic [STATE_W-1:0]      new_state;
    logic [NTH_W-1:0]        nth;

    modport source (output valid, func, task_kind, service_index, task_id, new_state, nth,
                    input ready);
    modport sink   (input valid, func, task_kind, service_index, task_id, new_state, nth,
                    output ready);
endinterface

interface tstl_rsp_if
    import tstl_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic [ID_W-1:0]         result_id;
    logic [KIND_W-1:0]       result_kind;
    logic signed [SVC_W-1:0] result_service;
    logic [STATE_W-1:0]      result_state;
    logic [LIVE_W-1:0]       live_count;

    modport source (output valid, ok, result_id, result_kind, result_service, result_state,
                    live_count, input ready);
    modport sink   (input valid, ok, result_id, result_kind, result_service, result_state,
                    live_count, output ready);
endinterface

### rtl/core/tstl_cell.sv
// One slot of the task table: holds the slot fields and acts on the query
// beat as it passes, then hands the beat to the next cell. Uses tstl_pkg.
module tstl_cell
    import tstl_pkg::*;
#(
    parameter int CNT_W = 5
)(
    input  logic              clk,
    input  logic              rst_n,
    input  tstl_query_t       q_in,
    input  logic [CNT_W-1:0]  cnt_in,
    output tstl_query_t       q_out,
    output logic [CNT_W-1:0]  cnt_out
);

    logic                    used_reg;
    logic [ID_W-1:0]         id_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic signed [SVC_W-1:0] svc_reg;
    logic [STATE_W-1:0]      state_reg;

    tstl_query_t             q_reg, q_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic live_q;
    logic hit_free;
    logic hit_set;
    logic get_used;
    logic hit_get;
    logic move_ok;

    // Decide what this slot does with the passing beat
    always_comb
    begin
        live_q   = q_in.valid && !q_in.done;
        hit_free = live_q && (q_in.func == FUNC_CREATE) && !used_reg;
        hit_set  = live_q && (q_in.func == FUNC_SET) && used_reg && (id_reg == q_in.tid);
        get_used = live_q && (q_in.func == FUNC_GET) && used_reg;
        hit_get  = get_used &&
                   ({{NTH_W{1'b0}}, cnt_in} == {{CNT_W{1'b0}}, q_in.nth});
        move_ok  = move_allowed(state_reg, q_in.new_state);
    end

    // Update the beat for the next cell
    always_comb
    begin
        q_next   = q_in;
        cnt_next = cnt_in;
        if (hit_free)
        begin
            q_next.done = 1'b1;
            q_next.ok   = 1'b1;
            q_next.rid  = q_in.new_id;
        end
        if (hit_set)
        begin
            q_next.done = 1'b1;
            q_next.ok   = move_ok;
        end
        if (hit_get)
        begin
            q_next.done   = 1'b1;
            q_next.ok     = 1'b1;
            q_next.rid    = id_reg;
            q_next.rkind  = kind_reg;
            q_next.rsvc   = svc_reg;
            q_next.rstate = state_reg;
        end
        else if (get_used)
        begin
            cnt_next = cnt_in + CNT_W'(1);
        end
    end

    // Slot used bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (hit_free)
        begin
            used_reg <= 1'b1;
        end
    end

    // Slot fields, written by create and set-state
    always_ff @(posedge clk)
    begin
        if (hit_free)
        begin
            id_reg    <= q_in.new_id;
            kind_reg  <= q_in.kind;
            svc_reg   <= q_in.service;
            state_reg <= ST_CREATED;
        end
        else if (hit_set && move_ok)
        begin
            state_reg <= q_in.new_state;
        end
    end

    // Beat register toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            q_reg   <= q_next;
            cnt_reg <= cnt_next;
        end
    end

    assign q_out   = q_reg;
    assign cnt_out = cnt_reg;

endmodule

### rtl/core/task_slot_table_lifecycle_top.sv
// Task slot table with a fixed lifecycle: top level with the launch register,
// id and live counters, and response buffer. Uses tstl_pkg, tstl_ifs, tstl_cell.
//
// One request is handled at a time. A request beat goes into a launch
// register and then walks the row of TASK_SLOTS cells, one cell per clock,
// each cell holding one slot. It then passes through a pending register into
// the output register, where the response is presented. The next request is
// taken once the previous response is in the output register, even if that
// response has not yet been taken. The lowest free slot, the lowest matching
// id and the nth live slot are found on the way down the row.
// Used bits clear at reset; no clearing pass is needed.
module task_slot_table_lifecycle_top
    import tstl_pkg::*;
#(
    parameter int TASK_SLOTS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    tstl_req_if.sink    req,
    tstl_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    tstl_query_t       chain_q   [TASK_SLOTS+1];
    logic [CNT_W-1:0]  chain_cnt [TASK_SLOTS+1];

    tstl_query_t       launch_reg, launch_next;
    logic              busy_reg, busy_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [CNT_W+LIVE_W-1:0] live_wide;

    tstl_query_t       pend_reg;
    logic              pend_valid_reg, pend_valid_next;
    logic [LIVE_W-1:0] pend_live_reg;

    logic              out_valid_reg, out_valid_next;
    tstl_query_t       out_reg;
    logic [LIVE_W-1:0] out_live_reg;

    tstl_query_t       tail;
    logic              req_beat;
    logic              create_done;
    logic              move_out;

    assign tail      = chain_q[TASK_SLOTS];
    assign req.ready = !busy_reg;
    assign req_beat  = req.valid && !busy_reg;

    // Build the launch beat from the request
    always_comb
    begin
        launch_next           = '0;
        launch_next.valid     = req_beat;
        launch_next.func      = req.func;
        launch_next.kind      = req.task_kind;
        launch_next.service   = req.service_index;
        launch_next.tid       = req.task_id;
        launch_next.new_state = req.new_state;
        launch_next.nth       = req.nth;
        launch_next.new_id    = next_id_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= '0;
        end
        else
        begin
            launch_reg <= launch_next;
        end
    end

    assign chain_q[0]   = launch_reg;
    assign chain_cnt[0] = '0;

    // Row of slot cells
    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        tstl_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .q_in    (chain_q[i]),
            .cnt_in  (chain_cnt[i]),
            .q_out   (chain_q[i+1]),
            .cnt_out (chain_cnt[i+1])
        );
    end

    // Counters, updated when a beat leaves the row
    always_comb
    begin
        create_done  = tail.valid && (tail.func == FUNC_CREATE) && tail.ok;
        next_id_next = next_id_reg;
        live_next    = live_reg;
        if (create_done)
        begin
            next_id_next = (next_id_reg == ID_LAST) ? ID_FIRST : next_id_reg + ID_FIRST;
            live_next    = live_reg + CNT_W'(1);
        end
        live_wide = {{LIVE_W{1'b0}}, live_next};
    end

    // Handshake flags
    always_comb
    begin
        move_out        = pend_valid_reg && (!out_valid_reg || rsp.ready);
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (move_out)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
        if (tail.valid)
        begin
            pend_valid_next = 1'b1;
        end
        if (req_beat)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            next_id_reg    <= ID_FIRST;
            live_reg       <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            next_id_reg    <= next_id_next;
            live_reg       <= live_next;
        end
    end

    // Result payload: pending slot then output register
    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            pend_reg      <= tail;
            pend_live_reg <= live_wide[LIVE_W-1:0];
        end
        if (move_out)
        begin
            out_reg      <= pend_reg;
            out_live_reg <= pend_live_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_reg.ok;
    assign rsp.result_id      = out_reg.rid;
    assign rsp.result_kind    = out_reg.rkind;
    assign rsp.result_service = out_reg.rsvc;
    assign rsp.result_state   = out_reg.rstate;
    assign rsp.live_count     = out_live_reg;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for task_slot_table_lifecycle_top: directed and random create, move and
// read requests, each reply checked against a shadow copy of the slot table.
// Depends on tstl_pkg, the tstl_req_if / tstl_rsp_if channels and the RTL top.
module tb
    import tstl_pkg::*;
;

    localparam int SLOTS        = 16;
    localparam int RANDOM_OPS   = 1575;
    localparam int CALM_OPS     = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 2 * (SLOTS + 3);

    // Codes the package leaves unnamed
    localparam logic [1:0]         FUNC_SPARE = 2'd3;
    localparam logic [STATE_W-1:0] ST_SPARE_6 = 3'd6;
    localparam logic [STATE_W-1:0] ST_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [1:0]              func;
        logic [KIND_W-1:0]       kind;
        logic signed [SVC_W-1:0] svc;
        logic [ID_W-1:0]         tid;
        logic [STATE_W-1:0]      new_state;
        logic [NTH_W-1:0]        nth;
    } task_op_t;

    typedef struct packed {
        logic                    ok;
        logic [ID_W-1:0]         id;
        logic [KIND_W-1:0]       kind;
        logic signed [SVC_W-1:0] svc;
        logic [STATE_W-1:0]      state;
        logic [LIVE_W-1:0]       live;
    } task_reply_t;

    // Shadow of the slot table plus the replies it still owes
    class task_table_model;
        logic                    used   [SLOTS];
        logic [ID_W-1:0]         ids    [SLOTS];
        logic [KIND_W-1:0]       kinds  [SLOTS];
        logic signed [SVC_W-1:0] svcs   [SLOTS];
        logic [STATE_W-1:0]      states [SLOTS];
        logic [ID_W-1:0]         id_next;
        task_reply_t             awaited[$];
        int mismatches, replies_seen;
        int creates_ok, creates_full, moves_ok, moves_refused, reads_hit, reads_miss;

        function new();
            foreach (used[i])
                used[i] = 1'b0;
            id_next = ID_FIRST;
        endfunction

        function int live_tasks();
            int n;
            n = 0;
            foreach (used[i])
                if (used[i])
                    n++;
            return n;
        endfunction

        function bit move_ok(logic [STATE_W-1:0] cur, logic [STATE_W-1:0] to);
            case (cur)
                ST_CREATED:    return to inside {ST_QUEUED, ST_DENIED, ST_FAILED};
                ST_QUEUED:     return to inside {ST_DISPATCHED, ST_DENIED, ST_FAILED};
                ST_DISPATCHED: return to inside {ST_DONE, ST_FAILED};
                default:       return 1'b0;
            endcase
        endfunction

        // Apply one accepted request and queue the reply it must produce
        function void note_request(task_op_t op);
            task_reply_t r;
            int seen;
            bit hit;
            r = '0;
            seen = 0;
            hit = 1'b0;
            case (op.func)
                FUNC_CREATE:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!hit && !used[i])
                        begin
                            hit = 1'b1;
                            used[i] = 1'b1;
                            ids[i] = id_next;
                            kinds[i] = op.kind;
                            svcs[i] = op.svc;
                            states[i] = ST_CREATED;
                            r.ok = 1'b1;
                            r.id = id_next;
                            id_next = (id_next == ID_LAST) ? ID_FIRST : id_next + 1'b1;
                        end
                    if (hit) creates_ok++; else creates_full++;
                end
                FUNC_SET:
                begin
                    // lowest used slot with a matching id decides
                    for (int i = 0; i < SLOTS; i++)
                        if (!hit && used[i] && ids[i] == op.tid)
                        begin
                            hit = 1'b1;
                            if (move_ok(states[i], op.new_state))
                            begin
                                states[i] = op.new_state;
                                r.ok = 1'b1;
                            end
                        end
                    if (r.ok) moves_ok++; else moves_refused++;
                end
                FUNC_GET:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!hit && used[i])
                        begin
                            if (seen == op.nth)
                            begin
                                hit = 1'b1;
                                r.ok = 1'b1;
                                r.id = ids[i];
                                r.kind = kinds[i];
                                r.svc = svcs[i];
                                r.state = states[i];
                            end
                            seen++;
                        end
                    if (hit) reads_hit++; else reads_miss++;
                end
                default: ;
            endcase
            r.live = LIVE_W'(live_tasks());
            awaited.push_back(r);
        endfunction

        function void check_response(task_reply_t got);
            task_reply_t want;
            replies_seen++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                $display("%0t: reply beat with none awaited: ok=%0b id=%0d live=%0d",
                         $time, got.ok, got.id, got.live);
                return;
            end
            want = awaited.pop_front();
            if (got !== want)
            begin
                mismatches++;
                $display({"%0t: reply mismatch: expected ok=%0b id=%0d kind=%0d svc=%0d ",
                          "state=%0d live=%0d, actual ok=%0b id=%0d kind=%0d svc=%0d ",
                          "state=%0d live=%0d"},
                         $time, want.ok, want.id, want.kind, want.svc, want.state,
                         want.live, got.ok, got.id, got.kind, got.svc, got.state,
                         got.live);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    tstl_req_if req_ch();
    tstl_rsp_if rsp_ch();

    task_table_model shadow = new();

    task_slot_table_lifecycle_top #(.TASK_SLOTS(SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic task_op_t make_op(logic [1:0] func, logic [KIND_W-1:0] kind,
                                         logic [SVC_W-1:0] svc, logic [ID_W-1:0] tid,
                                         logic [STATE_W-1:0] st, logic [NTH_W-1:0] nth);
        task_op_t op;
        op.func = func;
        op.kind = kind;
        op.svc = svc;
        op.tid = tid;
        op.new_state = st;
        op.nth = nth;
        return op;
    endfunction

    // Mostly well-formed lifecycle traffic on live ids, with some noise mixed in
    function automatic task_op_t random_op();
        task_op_t op;
        int n, pick;
        logic [STATE_W-1:0] cur_state;
        logic [STATE_W-1:0] opts[$];
        op.func = FUNC_GET;
        op.kind = KIND_W'($urandom_range(0, 15));
        op.svc = SVC_W'($urandom_range(0, 255));
        op.tid = ID_W'($urandom_range(0, 65535));
        op.new_state = STATE_W'($urandom_range(0, 7));
        op.nth = NTH_W'($urandom_range(0, 15));
        n = shadow.live_tasks();
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op.func = FUNC_CREATE;
        else if (pick < 5)
            op.func = FUNC_SPARE;
        else if (pick < 60)
        begin
            op.func = FUNC_SET;
            if (n > 0 && $urandom_range(0, 99) < 85)
            begin
                pick = $urandom_range(0, n - 1);
                cur_state = ST_DONE;
                for (int i = 0; i < SLOTS; i++)
                    if (shadow.used[i])
                    begin
                        if (pick == 0)
                        begin
                            op.tid = shadow.ids[i];
                            cur_state = shadow.states[i];
                        end
                        pick--;
                    end
                case (cur_state)
                    ST_CREATED:    opts = '{ST_QUEUED, ST_DENIED, ST_FAILED};
                    ST_QUEUED:     opts = '{ST_DISPATCHED, ST_DENIED, ST_FAILED};
                    ST_DISPATCHED: opts = '{ST_DONE, ST_FAILED};
                    default:       opts = {};
                endcase
                if (opts.size() != 0 && $urandom_range(0, 3) != 0)
                    op.new_state = opts[$urandom_range(0, opts.size() - 1)];
            end
        end
        else if ($urandom_range(0, 4) != 0)
            op.nth = NTH_W'($urandom_range(0, (n < SLOTS) ? n : SLOTS - 1));
        return op;
    endfunction

    // Present one request beat and hold it until the block takes it
    task automatic send_op(task_op_t op);
        req_ch.valid <= 1'b1;
        req_ch.func <= op.func;
        req_ch.task_kind <= op.kind;
        req_ch.service_index <= op.svc;
        req_ch.task_id <= op.tid;
        req_ch.new_state <= op.new_state;
        req_ch.nth <= op.nth;
        do
            @(posedge clk);
        while (!req_ch.ready);
        shadow.note_request(op);
    endtask

    task automatic pause_req(int rate);
        int g;
        if (!calm && $urandom_range(1, 100) <= rate)
        begin
            g = $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Request side
    initial
    begin : stimulus
        task_op_t directed[$];
        int gap_rate;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FUNC_CREATE;
        req_ch.task_kind <= '0;
        req_ch.service_index <= '0;
        req_ch.task_id <= '0;
        req_ch.new_state <= ST_CREATED;
        req_ch.nth <= '0;
        gap_rate = 20;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then extremes of kind and service, legal and illegal moves
        directed.push_back(make_op(FUNC_GET,    4'd0,  8'h00, 16'd0,    ST_CREATED,    4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd1,    ST_QUEUED,     4'd0));
        directed.push_back(make_op(FUNC_SPARE,  4'd9,  8'h55, 16'd1,    ST_QUEUED,     4'd3));
        directed.push_back(make_op(FUNC_CREATE, 4'd0,  8'hFF, 16'd0,    ST_CREATED,    4'd0));
        directed.push_back(make_op(FUNC_CREATE, 4'd15, 8'h7F, 16'hFFFF, ST_SPARE_7,    4'd15));
        directed.push_back(make_op(FUNC_CREATE, 4'd5,  8'h80, 16'd0,    ST_CREATED,    4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd1,    ST_CREATED,    4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd1,    ST_SPARE_6,    4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd1,    ST_QUEUED,     4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd1,    ST_SPARE_7,    4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd1,    ST_DISPATCHED, 4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd1,    ST_DONE,       4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd1,    ST_FAILED,     4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd2,    ST_DENIED,     4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd2,    ST_QUEUED,     4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd3,    ST_QUEUED,     4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd3,    ST_DENIED,     4'd0));
        directed.push_back(make_op(FUNC_CREATE, 4'd10, 8'h00, 16'd0,    ST_CREATED,    4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd4,    ST_FAILED,     4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'd0,    ST_FAILED,     4'd0));
        directed.push_back(make_op(FUNC_SET,    4'd0,  8'h00, 16'hFFFF, ST_QUEUED,     4'd0));
        directed.push_back(make_op(FUNC_GET,    4'd0,  8'h00, 16'd0,    ST_CREATED,    4'd1));
        directed.push_back(make_op(FUNC_GET,    4'd0,  8'h00, 16'd0,    ST_CREATED,    4'd3));
        directed.push_back(make_op(FUNC_GET,    4'd0,  8'h00, 16'd0,    ST_CREATED,    4'd4));
        directed.push_back(make_op(FUNC_GET,    4'd0,  8'h00, 16'd0,    ST_CREATED,    4'd15));
        foreach (directed[k])
        begin
            send_op(directed[k]);
            pause_req(gap_rate);
        end

        // random traffic; the gap rate shifts every few dozen beats, last part runs flat out
        for (int k = 0; k < RANDOM_OPS; k++)
        begin
            calm = (k >= RANDOM_OPS - CALM_OPS);
            if (k % 40 == 0)
                case ($urandom_range(0, 2))
                    0:       gap_rate = 0;
                    1:       gap_rate = 15;
                    default: gap_rate = 40;
                endcase
            send_op(random_op());
            pause_req(gap_rate);
        end
        req_ch.valid <= 1'b0;

        while (shadow.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"Covered %0d replies: %0d tasks created, %0d creates on a full table, ",
                  "%0d moves taken, %0d refused,"},
                 shadow.replies_seen, shadow.creates_ok, shadow.creates_full,
                 shadow.moves_ok, shadow.moves_refused);
        $display("  %0d reads of a live task, %0d reads past the end; %0d mismatches.",
                 shadow.reads_hit, shadow.reads_miss, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Reply side: ready stalls at random, and the stall rate changes over time
    initial
    begin : reply_side
        int stall, rate, span;
        stall = 0;
        rate = 0;
        span = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                span = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0:       rate = 0;
                    1:       rate = 15;
                    default: rate = 40;
                endcase
            end
            span--;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(1, 100) <= rate)
                    stall = $urandom_range(1, 4);
            end
        end
    end

    // Reply monitor
    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.check_response(task_reply_t'{rsp_ch.ok, rsp_ch.result_id,
                                                rsp_ch.result_kind, rsp_ch.result_service,
                                                rsp_ch.result_state, rsp_ch.live_count});

    // Watchdog: too long with no beat on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat on either channel for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
